### hdl/ssplit_pkg.sv
`timescale 1ns / 1ps

package ssplit_pkg;

    localparam int MaxSubfields  = 32;
    localparam int MaxFieldBytes = 65535;
    localparam int IqDepthDef    = 4;
    localparam int RqDepthDef    = 4;

    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CfgSpaceSep   = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgDigitSplit = 1'd1;

    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChPipe  = 8'h7C;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChUnder = 8'h5F;
    localparam logic [7:0] ChHash  = 8'h23;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChSoh   = 8'h01;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChNone  = 8'h00;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_field;
        logic       is_num;
        logic       is_sep;
        logic       is_space;
        logic       digit_split;
    } t_cls;

    typedef struct packed {
        logic [5:0]  item_index;
        logic [15:0] item_start;
        logic [15:0] item_length;
        logic [7:0]  separator;
        logic        double_space;
        logic        is_integer;
        logic [62:0] int_value;
        logic [15:0] lead_zeros;
        logic        last_item;
    } t_result;

    typedef struct packed {
        logic first_valid;
        logic second_valid;
    } t_rq_wr;

endpackage

### hdl/ssplit_front.sv
`timescale 1ns / 1ps

module ssplit_front #(
    parameter int DEPTH = ssplit_pkg::IqDepthDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [7:0]                       i_char_byte,
    input  logic                             i_end_of_field,
    input  logic                             i_cfg_we,
    input  logic [ssplit_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic                             i_cfg_data,
    output ssplit_pkg::t_cls                 o_cls,
    output logic                             o_cls_valid,
    input  logic                             i_cls_take
);
    import ssplit_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cls            r_q [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_space_sep, r_digit_split;
    t_cls            w_entry;
    logic            w_push, w_pop;

    always_comb begin
        w_entry.char_byte    = i_char_byte;
        w_entry.end_of_field = i_end_of_field;
        w_entry.is_num       = i_char_byte inside {[ChZero:ChNine]};
        w_entry.is_sep       = (i_char_byte inside {ChColon, ChSemi, ChSlash, ChPipe,
                                                    ChDot, ChUnder, ChHash})
                               || (r_space_sep && (i_char_byte inside {ChSpace, ChTab, ChSoh}));
        w_entry.is_space     = (i_char_byte == ChSpace);
        w_entry.digit_split  = r_digit_split;
    end

    assign o_full      = (r_cnt == CntW'(DEPTH));
    assign o_cls_valid = (r_cnt != '0);
    assign o_cls       = r_q[r_rd];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cls_take && o_cls_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr          <= '0;
            r_rd          <= '0;
            r_cnt         <= '0;
            r_space_sep   <= 1'b1;
            r_digit_split <= 1'b0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgSpaceSep:   r_space_sep   <= i_cfg_data;
                    CfgDigitSplit: r_digit_split <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_entry;
        end
    end

endmodule

### hdl/ssplit_back.sv
`timescale 1ns / 1ps

module ssplit_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssplit_pkg::t_cls     i_cls,
    input  logic                 i_cls_valid,
    output logic                 o_cls_take,
    input  logic                 i_rq_room,
    output ssplit_pkg::t_rq_wr   o_wr,
    output ssplit_pkg::t_result  o_res0,
    output ssplit_pkg::t_result  o_res1
);
    import ssplit_pkg::*;

    typedef struct packed {
        logic [15:0] begin_pos;
        logic [15:0] bytes;
        logic        starts_digit;
        logic        all_digits;
        logic        overflow;
        logic [62:0] acc;
        logic [15:0] zero_run;
        logic        zero_open;
    } t_item;

    logic [15:0] r_pos, n_pos;
    logic [5:0]  r_idx, n_idx;
    logic        r_fim, n_fim;
    logic        r_sp, n_sp;
    logic        r_as, n_as;
    t_item       r_item, n_item;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v < 16'(MaxFieldBytes)) ? v + 16'd1 : 16'(MaxFieldBytes);
    endfunction

    function automatic t_item add_byte(input t_item it, input logic fresh,
                                       input t_cls cl, input logic [15:0] pos);
        t_item       o;
        logic [66:0] sum;
        o = it;
        if (fresh) begin
            o.begin_pos    = pos;
            o.bytes        = '0;
            o.starts_digit = cl.is_num;
            o.all_digits   = 1'b1;
            o.overflow     = 1'b0;
            o.acc          = '0;
            o.zero_run     = '0;
            o.zero_open    = 1'b1;
        end
        o.bytes = sat_inc(o.bytes);
        sum = ({4'b0, o.acc} << 3) + ({4'b0, o.acc} << 1)
              + {63'b0, cl.char_byte[3:0]};
        if (!cl.is_num) begin
            o.all_digits = 1'b0;
        end else if (!o.overflow) begin
            if (sum[66:63] != 4'b0) begin
                o.overflow = 1'b1;
            end else begin
                o.acc = sum[62:0];
            end
        end
        if (o.zero_open && (cl.char_byte == ChZero)) begin
            o.zero_run = sat_inc(o.zero_run);
        end else begin
            o.zero_open = 1'b0;
        end
        return o;
    endfunction

    function automatic t_result make_result(input t_item it, input logic [5:0] idx,
                                            input logic [7:0] sep, input logic dbl,
                                            input logic last);
        t_result     o;
        logic        is_int;
        logic [15:0] lim;
        is_int          = it.starts_digit && it.all_digits && !it.overflow;
        lim             = it.bytes - 16'd1;
        o.item_index    = idx;
        o.item_start    = it.begin_pos;
        o.item_length   = it.bytes;
        o.separator     = sep;
        o.double_space  = dbl;
        o.is_integer    = is_int;
        o.int_value     = is_int ? it.acc : '0;
        o.lead_zeros    = !is_int ? '0 : ((it.zero_run > lim) ? lim : it.zero_run);
        o.last_item     = last;
        return o;
    endfunction

    function automatic logic hits_final(input logic [5:0] idx);
        return 7'(idx) >= 7'(MaxSubfields - 1);
    endfunction

    always_comb begin
        logic        a_v, a_dbl, a_last, b_v, finish;
        logic [7:0]  a_sep;
        logic        as_w, fim_w;
        logic [5:0]  idx_w;
        t_item       item_w;
        t_result     res_a, res_b;

        o_cls_take = i_cls_valid && i_rq_room;

        a_v    = 1'b0;
        a_sep  = ChNone;
        a_dbl  = 1'b0;
        a_last = 1'b0;
        b_v    = 1'b0;
        finish = 1'b0;
        as_w   = r_as;
        fim_w  = r_fim;
        idx_w  = r_idx;
        n_sp   = r_sp;

        if (r_sp) begin
            n_sp   = 1'b0;
            a_v    = 1'b1;
            a_sep  = ChSpace;
            a_dbl  = i_cls.is_space;
            a_last = i_cls.is_space && i_cls.end_of_field;
            finish = i_cls.is_space;
            idx_w  = r_idx + 6'd1;
            fim_w  = r_fim || hits_final(idx_w);
            as_w   = 1'b1;
        end

        if (!finish && !as_w && !fim_w) begin
            if (i_cls.is_sep) begin
                finish = 1'b1;
                if (i_cls.is_space && !i_cls.end_of_field) begin
                    n_sp = 1'b1;
                end else begin
                    a_v    = 1'b1;
                    a_sep  = i_cls.char_byte;
                    a_last = i_cls.end_of_field;
                    idx_w  = r_idx + 6'd1;
                    fim_w  = r_fim || hits_final(idx_w);
                    as_w   = 1'b1;
                end
            end else if (i_cls.digit_split
                         && (i_cls.is_num != r_item.starts_digit)) begin
                a_v   = 1'b1;
                idx_w = r_idx + 6'd1;
                fim_w = r_fim || hits_final(idx_w);
                as_w  = 1'b1;
            end
        end

        item_w = add_byte(r_item, as_w, i_cls, r_pos);
        res_a  = make_result(r_item, r_idx, a_sep, a_dbl, a_last);
        res_b  = make_result(item_w, idx_w, ChNone, 1'b0, 1'b1);

        n_item = r_item;
        n_idx  = idx_w;
        n_fim  = fim_w;
        n_as   = as_w;
        n_pos  = (r_pos < 16'(MaxFieldBytes)) ? r_pos + 16'd1 : r_pos;
        if (!finish) begin
            n_item = item_w;
            n_as   = 1'b0;
            b_v    = i_cls.end_of_field;
        end
        if (i_cls.end_of_field) begin
            n_pos = '0;
            n_idx = '0;
            n_fim = 1'b0;
            n_sp  = 1'b0;
            n_as  = 1'b1;
        end

        o_wr.first_valid  = o_cls_take && (a_v || b_v);
        o_wr.second_valid = o_cls_take && a_v && b_v;
        o_res0            = a_v ? res_a : res_b;
        o_res1            = res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_idx <= '0;
            r_fim <= 1'b0;
            r_sp  <= 1'b0;
            r_as  <= 1'b1;
        end else if (o_cls_take) begin
            r_pos <= n_pos;
            r_idx <= n_idx;
            r_fim <= n_fim;
            r_sp  <= n_sp;
            r_as  <= n_as;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_take) begin
            r_item <= n_item;
        end
    end

endmodule

### hdl/ssplit_rq.sv
`timescale 1ns / 1ps

module ssplit_rq #(
    parameter int DEPTH = ssplit_pkg::RqDepthDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssplit_pkg::t_rq_wr   i_wr,
    input  ssplit_pkg::t_result  i_res0,
    input  ssplit_pkg::t_result  i_res1,
    output logic                 o_room,
    output ssplit_pkg::t_result  o_head,
    output logic                 o_empty,
    input  logic                 i_pop
);
    import ssplit_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_result         r_q [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd, n_wr, n_rd, w_wr1;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_room  = (r_cnt <= CntW'(DEPTH - 2));
    assign o_head  = r_q[r_rd];
    assign w_pop   = i_pop && !o_empty;
    assign w_wr1   = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;

    always_comb begin
        n_wr = r_wr;
        if (i_wr.second_valid) begin
            n_wr = (w_wr1 == PtrW'(DEPTH - 1)) ? '0 : w_wr1 + 1'b1;
        end else if (i_wr.first_valid) begin
            n_wr = w_wr1;
        end
        n_rd = r_rd;
        if (w_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        n_cnt = r_cnt + CntW'(i_wr.first_valid) + CntW'(i_wr.second_valid)
                - CntW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.first_valid) begin
            r_q[r_wr] <= i_res0;
        end
        if (i_wr.second_valid) begin
            r_q[w_wr1] <= i_res1;
        end
    end

endmodule

### hdl/subfield_splitter_core.sv
`timescale 1ns / 1ps

// Splits a byte-serial text field into subfields at separator bytes and, when enabled, at
// digit/non-digit changes, reporting position, length, separator and decimal value of each.
// One byte is accepted per cycle while the input queue is not full: a classified byte waits
// in a small input queue, the split engine handles one byte per cycle and writes up to two
// transactions into the result queue, and results leave at one per cycle while any wait. A
// result passes the registered input and result queues before it reaches the outputs, while
// a result closed by a space waits for the next byte; the engine pauses only while the input
// queue is empty or the result queue has fewer than two free entries. A register write takes
// effect from the next byte accepted and belongs between fields, with nothing in flight.
module subfield_splitter_core #(
    parameter int IQ_DEPTH = ssplit_pkg::IqDepthDef,
    parameter int RQ_DEPTH = ssplit_pkg::RqDepthDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_char_byte,
    input  logic                           i_end_of_field,
    input  logic                           i_cfg_we,
    input  logic [ssplit_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic                           i_cfg_data,
    output logic                           empty,
    input  logic                           pop,
    output logic [5:0]                     o_item_index,
    output logic [15:0]                    o_item_start,
    output logic [15:0]                    o_item_length,
    output logic [7:0]                     o_separator,
    output logic                           o_double_space,
    output logic                           o_is_integer,
    output logic [62:0]                    o_int_value,
    output logic [15:0]                    o_lead_zeros,
    output logic                           o_last_item
);
    import ssplit_pkg::*;

    t_cls    w_cls;
    logic    w_cls_valid, w_cls_take, w_room;
    t_rq_wr  w_wr;
    t_result w_res0, w_res1, w_head;

    ssplit_front #(.DEPTH(IQ_DEPTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_char_byte    (i_char_byte),
        .i_end_of_field (i_end_of_field),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_cls          (w_cls),
        .o_cls_valid    (w_cls_valid),
        .i_cls_take     (w_cls_take)
    );

    ssplit_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (w_cls),
        .i_cls_valid (w_cls_valid),
        .o_cls_take  (w_cls_take),
        .i_rq_room   (w_room),
        .o_wr        (w_wr),
        .o_res0      (w_res0),
        .o_res1      (w_res1)
    );

    ssplit_rq #(.DEPTH(RQ_DEPTH)) u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .o_room  (w_room),
        .o_head  (w_head),
        .o_empty (empty),
        .i_pop   (pop)
    );

    assign o_item_index    = w_head.item_index;
    assign o_item_start    = w_head.item_start;
    assign o_item_length   = w_head.item_length;
    assign o_separator     = w_head.separator;
    assign o_double_space  = w_head.double_space;
    assign o_is_integer    = w_head.is_integer;
    assign o_int_value     = w_head.int_value;
    assign o_lead_zeros    = w_head.lead_zeros;
    assign o_last_item     = w_head.last_item;

endmodule
